@@ rtl/core/integer_stack_calculator_assert.svh @@
// ----------------------------------------------------------------------------
// integer stack calculator assertion macros
// shared property forms used by the calculator rtl
// ----------------------------------------------------------------------------
`ifndef INTEGER_STACK_CALCULATOR_ASSERT_SVH
`define INTEGER_STACK_CALCULATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define ISC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define ISC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/isc_pkg.sv @@
// ----------------------------------------------------------------------------
// isc_pkg
// types and constants shared by the integer stack calculator modules
// ----------------------------------------------------------------------------
package isc_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int FUNC_W      = 4;
  localparam int LIMIT_W     = 31;
  localparam int DIV_CNT_W   = $clog2(DATA_W);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd1000000000;

  typedef enum logic [FUNC_W-1:0] {
    FN_START = 4'd0,
    FN_NUM   = 4'd1,
    FN_POP   = 4'd2,
    FN_INV   = 4'd3,
    FN_DUP   = 4'd4,
    FN_SWP   = 4'd5,
    FN_ADD   = 4'd6,
    FN_SUB   = 4'd7,
    FN_MUL   = 4'd8,
    FN_DIV   = 4'd9,
    FN_MOD   = 4'd10,
    FN_END   = 4'd11
  } func_e;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quot;
    logic [DATA_W-1:0] rem;
  } div_rsp_t;

endpackage

@@ rtl/core/isc_ram.sv @@
// ----------------------------------------------------------------------------
// isc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module isc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/core/isc_div.sv @@
// ----------------------------------------------------------------------------
// isc_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module isc_div
  import isc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DATA_W-1:0]    quo_q;
  logic [DATA_W-1:0]    rem_q;
  logic [DATA_W-1:0]    dvs_q;

  logic [DATA_W:0]      shifted;
  logic [DATA_W:0]      trial;
  logic                 fits;

  assign shifted = {rem_q, quo_q[DATA_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign fits    = ~trial[DATA_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '1;
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - DIV_CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo_q <= {quo_q[DATA_W-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

@@ rtl/core/integer_stack_calculator.sv @@
// ----------------------------------------------------------------------------
// integer_stack_calculator
// stack machine for 32-bit integer programs with an end-of-run check
// ----------------------------------------------------------------------------
// Instructions arrive on the s_axis channel: the opcode in tuser, the operand
// in tdata. START, NUM, POP, spare codes and any instruction that underflows
// or overflows end in idle; INV and DUP add a read state, ADD and SUB an
// execute state too, SWP and MUL a swap write or write-back, END an end and
// an output state that waits for a free output. DIV and MOD wait on the
// shared restoring divider, one quotient bit per cycle. One instruction at
// a time; s_axis_tready is low while the block is busy. The stack lives in
// a 1024-entry ram with one write and one registered read port, so operands
// are fetched one per cycle. Only END produces a transaction on m_axis: the
// value in tdata and the error flag in tuser. The result sits in an output
// register; if the receiver stalls, the block still accepts instructions
// and only a following END waits for the register to drain.
// Reset empties the stack, clears the error flag and loads the magnitude
// limit with 1000000000; the ram needs no clearing pass. cfg_we_i writes the
// limit; the user must use it only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
`include "integer_stack_calculator_assert.svh"

module integer_stack_calculator
  import isc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [DATA_W-1:0]  s_axis_tdata,   // [31:0] operand
  input  logic [FUNC_W-1:0]  s_axis_tuser,   // [3:0] func
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [DATA_W-1:0]  m_axis_tdata,   // [31:0] value
  output logic               m_axis_tuser,   // [0] error
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD2,
    S_EXEC,
    S_SWP2,
    S_DIV,
    S_WB,
    S_END,
    S_OUT
  } state_e;

  state_e             state_q;
  func_e              op_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               err_q;
  logic               end_ok_q;
  logic [LIMIT_W-1:0] limit_q;
  logic               out_valid_q;

  logic [DATA_W-1:0]  b_q;
  logic               a_neg_q;
  logic [DATA_W-1:0]  res_q;
  logic               res_err_q;
  logic [DATA_W-1:0]  out_value_q;
  logic               out_err_q;

  func_e              func_in;
  logic               accept;
  logic               empty;
  logic               full;
  logic               has_two;
  logic [CNT_W-1:0]   cnt_m1;
  logic [CNT_W-1:0]   cnt_m2;
  logic [PTR_W-1:0]   top_ptr;
  logic [PTR_W-1:0]   sec_ptr;
  logic [PTR_W-1:0]   push_ptr;
  logic               out_free;

  logic               mem_we;
  logic [PTR_W-1:0]   mem_waddr;
  logic [DATA_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [PTR_W-1:0]   mem_raddr;
  logic [DATA_W-1:0]  mem_rdata;

  logic [DATA_W-1:0]  prod;
  logic [DATA_W-1:0]  rd_mag;
  logic [DATA_W-1:0]  b_mag;
  logic               end_good;
  logic [DATA_W-1:0]  div_res;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign func_in  = func_e'(s_axis_tuser);
  assign accept   = s_axis_tvalid & s_axis_tready;
  assign empty    = (cnt_q == '0);
  assign full     = (cnt_q == CNT_W'(STACK_DEPTH));
  assign has_two  = (cnt_q >= CNT_W'(2));
  assign cnt_m1   = cnt_q - CNT_W'(1);
  assign cnt_m2   = cnt_q - CNT_W'(2);
  assign top_ptr  = cnt_m1[PTR_W-1:0];
  assign sec_ptr  = cnt_m2[PTR_W-1:0];
  assign push_ptr = cnt_q[PTR_W-1:0];
  assign out_free = ~out_valid_q | m_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_err_q;

  assign prod     = mem_rdata * b_q;
  assign rd_mag   = mem_rdata[DATA_W-1] ? (~mem_rdata + DATA_W'(1)) : mem_rdata;
  assign b_mag    = b_q[DATA_W-1] ? (~b_q + DATA_W'(1)) : b_q;
  assign end_good = end_ok_q & (rd_mag < DATA_W'(limit_q));

  // quotient takes the xor of the signs, remainder the sign of the dividend
  always_comb begin
    if (op_q == FN_DIV) begin
      div_res = (a_neg_q ^ b_q[DATA_W-1]) ? (~div_rsp.quot + DATA_W'(1)) : div_rsp.quot;
    end else begin
      div_res = a_neg_q ? (~div_rsp.rem + DATA_W'(1)) : div_rsp.rem;
    end
  end

  assign div_req.start    = (state_q == S_EXEC) & (b_q != '0) &
                            ((op_q == FN_DIV) | (op_q == FN_MOD));
  assign div_req.dividend = rd_mag;
  assign div_req.divisor  = b_mag;

  // stack ram port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = top_ptr;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = top_ptr;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (func_in)
            FN_START: begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = s_axis_tdata;
            end
            FN_NUM: begin
              mem_we    = ~full;
              mem_waddr = push_ptr;
              mem_wdata = s_axis_tdata;
            end
            FN_INV: mem_re = ~empty;
            FN_DUP: mem_re = ~empty & ~full;
            FN_SWP, FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MOD: mem_re = has_two;
            FN_END: begin
              mem_re    = 1'b1;
              mem_raddr = '0;
            end
            default: ;
          endcase
        end
      end
      S_RD2: begin
        if (op_q == FN_INV) begin
          mem_we    = 1'b1;
          mem_wdata = ~mem_rdata + DATA_W'(1);
        end else if (op_q == FN_DUP) begin
          mem_we    = 1'b1;
          mem_waddr = push_ptr;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = sec_ptr;
        end
      end
      S_EXEC: begin
        priority case (op_q)
          FN_SWP: mem_we = 1'b1;
          FN_ADD: begin
            mem_we    = 1'b1;
            mem_waddr = sec_ptr;
            mem_wdata = mem_rdata + b_q;
          end
          FN_SUB: begin
            mem_we    = 1'b1;
            mem_waddr = sec_ptr;
            mem_wdata = mem_rdata - b_q;
          end
          default: ;
        endcase
      end
      S_SWP2: begin
        mem_we    = 1'b1;
        mem_waddr = sec_ptr;
        mem_wdata = b_q;
      end
      S_WB: begin
        mem_we    = 1'b1;
        mem_waddr = sec_ptr;
        mem_wdata = res_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= FN_START;
      cnt_q       <= '0;
      err_q       <= 1'b0;
      end_ok_q    <= 1'b0;
      limit_q     <= LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q <= func_in;
            unique case (func_in)
              FN_START: begin
                cnt_q <= CNT_W'(1);
                err_q <= 1'b0;
              end
              FN_NUM: begin
                if (full) err_q <= 1'b1;
                else cnt_q <= cnt_q + CNT_W'(1);
              end
              FN_POP: begin
                if (empty) err_q <= 1'b1;
                else cnt_q <= cnt_m1;
              end
              FN_INV: begin
                if (empty) err_q <= 1'b1;
                else state_q <= S_RD2;
              end
              FN_DUP: begin
                if (empty || full) err_q <= 1'b1;
                else state_q <= S_RD2;
              end
              FN_SWP, FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MOD: begin
                if (!has_two) err_q <= 1'b1;
                else state_q <= S_RD2;
              end
              FN_END: begin
                end_ok_q <= (cnt_q == CNT_W'(1)) & ~err_q;
                cnt_q    <= '0;
                err_q    <= 1'b0;
                state_q  <= S_END;
              end
              default: ;
            endcase
          end
        end
        S_RD2: begin
          if (op_q == FN_INV) begin
            state_q <= S_IDLE;
          end else if (op_q == FN_DUP) begin
            cnt_q   <= cnt_q + CNT_W'(1);
            state_q <= S_IDLE;
          end else begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          priority case (op_q)
            FN_SWP: state_q <= S_SWP2;
            FN_ADD, FN_SUB: begin
              cnt_q   <= cnt_m1;
              state_q <= S_IDLE;
            end
            FN_MUL: state_q <= S_WB;
            FN_DIV: begin
              if (b_q == '0) begin
                // divisor is dropped, dividend stays
                err_q   <= 1'b1;
                cnt_q   <= cnt_m1;
                state_q <= S_IDLE;
              end else begin
                state_q <= S_DIV;
              end
            end
            FN_MOD: begin
              if (b_q == '0) begin
                err_q   <= 1'b1;
                state_q <= S_IDLE;
              end else begin
                state_q <= S_DIV;
              end
            end
            default: state_q <= S_IDLE;
          endcase
        end
        S_SWP2: state_q <= S_IDLE;
        S_DIV: begin
          if (div_rsp.done) state_q <= S_WB;
        end
        S_WB: begin
          cnt_q   <= cnt_m1;
          state_q <= S_IDLE;
        end
        S_END: state_q <= S_OUT;
        S_OUT: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD2) begin
      b_q <= mem_rdata;
    end
    if (state_q == S_EXEC) begin
      a_neg_q <= mem_rdata[DATA_W-1];
      res_q   <= prod;
    end
    if (state_q == S_DIV && div_rsp.done) begin
      res_q <= div_res;
    end
    if (state_q == S_END) begin
      res_q     <= end_good ? mem_rdata : '0;
      res_err_q <= ~end_good;
    end
    if (state_q == S_OUT && out_free) begin
      out_value_q <= res_q;
      out_err_q   <= res_err_q;
    end
  end

  isc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  isc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  `ISC_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
  `ISC_ASSERT_IMP(a_out_src, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == S_OUT, "result not from end sequence")
  `ISC_ASSERT_IMP(a_div_done, clk_i, rst_ni, div_rsp.done, state_q == S_DIV, "divider finished outside divide wait")
  `ISC_ASSERT_NXT(a_wb_pop, clk_i, rst_ni, state_q == S_WB, cnt_q == $past(cnt_q) - CNT_W'(1), "write-back did not pop")

endmodule
